// ===== src/ffws_pkg.sv =====
// Package with the constants, payload types and state encoding of the job scheduler.
`default_nettype none
package ffws_pkg;
   localparam int MAX_JOBS   = 64;
   localparam int JOB_BITS   = $clog2(MAX_JOBS);
   localparam int COUNT_BITS = $clog2(MAX_JOBS + 1);
   localparam int DAY_BITS   = 16;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_TICK = 1'b1
   } action_type;

   typedef struct packed {
      logic                action;
      logic [DAY_BITS-1:0] start_day;
      logic [DAY_BITS-1:0] end_day;
   } req_type;

   typedef struct packed {
      logic [DAY_BITS-1:0]   day;
      logic                  granted;
      logic [JOB_BITS-1:0]   job_index;
      logic [COUNT_BITS-1:0] served_total;
   } rsp_type;

   typedef struct packed {
      logic [DAY_BITS-1:0] start_day;
      logic [DAY_BITS-1:0] end_day;
   } window_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

// ===== src/ffws_window_mem.sv =====
// Single-port-write, registered-read memory holding the job windows.
`default_nettype none
module ffws_window_mem (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [ffws_pkg::JOB_BITS-1:0] wr_addr,
   input  wire ffws_pkg::window_type         wr_data,
   input  wire logic [ffws_pkg::JOB_BITS-1:0] rd_addr,
   output ffws_pkg::window_type              rd_data
);
   ffws_pkg::window_type mem_ff [ffws_pkg::MAX_JOBS];
   ffws_pkg::window_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

// ===== src/ffws_scan_ctrl.sv =====
// Sequencer that loads jobs and scans the window table one entry per cycle on each tick.
`default_nettype none
module ffws_scan_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ffws_pkg::req_type req_data,
   output logic                   res_valid,
   output ffws_pkg::rsp_type      res_data,
   input  wire logic              out_ready
);
   localparam logic [ffws_pkg::DAY_BITS-1:0] DayMax = '1;

   ffws_pkg::state_type state_ff, state_in;

   logic [ffws_pkg::COUNT_BITS-1:0] entry_count_ff;
   logic [ffws_pkg::COUNT_BITS-1:0] served_count_ff;
   logic [ffws_pkg::DAY_BITS-1:0]   day_ff;
   logic [ffws_pkg::MAX_JOBS-1:0]   served_ff;
   logic [ffws_pkg::COUNT_BITS-1:0] scan_idx_ff;
   logic [ffws_pkg::JOB_BITS-1:0]   chk_idx_ff;
   logic                            chk_vld_ff;
   logic                            granted_ff;
   logic [ffws_pkg::JOB_BITS-1:0]   hit_idx_ff;

   logic                            accept;
   logic                            do_load;
   logic                            issue;
   logic                            match;
   logic                            last_chk;
   logic                            finish;
   logic [ffws_pkg::COUNT_BITS-1:0] chk_next;
   ffws_pkg::window_type            wr_window;
   ffws_pkg::window_type            rd_window;

   assign accept  = req_valid && !req_stall;
   assign do_load = accept && (req_data.action == ffws_pkg::ACT_LOAD) &&
                    (entry_count_ff < ffws_pkg::COUNT_BITS'(ffws_pkg::MAX_JOBS));
   assign issue   = (state_ff == ffws_pkg::ST_SCAN) && (scan_idx_ff < entry_count_ff);
   assign match   = chk_vld_ff && !served_ff[chk_idx_ff] &&
                    (rd_window.start_day <= day_ff) && (rd_window.end_day >= day_ff);
   assign chk_next = {1'b0, chk_idx_ff} + ffws_pkg::COUNT_BITS'(1);
   assign last_chk = chk_vld_ff && (chk_next == entry_count_ff);
   assign finish   = (state_ff == ffws_pkg::ST_SCAN) && (match || last_chk);

   assign wr_window.start_day = req_data.start_day;
   assign wr_window.end_day   = req_data.end_day;

   ffws_window_mem u_mem (
      .clock   (clock),
      .wr_en   (do_load),
      .wr_addr (entry_count_ff[ffws_pkg::JOB_BITS-1:0]),
      .wr_data (wr_window),
      .rd_addr (scan_idx_ff[ffws_pkg::JOB_BITS-1:0]),
      .rd_data (rd_window)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffws_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      res_valid = 1'b0;
      case (state_ff)
         ffws_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (accept && (req_data.action == ffws_pkg::ACT_TICK)) begin
               if (entry_count_ff == '0) begin
                  state_in = ffws_pkg::ST_DONE;
               end else begin
                  state_in = ffws_pkg::ST_SCAN;
               end
            end
         end
         ffws_pkg::ST_SCAN: begin
            if (finish) begin
               state_in = ffws_pkg::ST_DONE;
            end
         end
         ffws_pkg::ST_DONE: begin
            res_valid = 1'b1;
            if (out_ready) begin
               state_in = ffws_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffws_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff  <= '0;
         served_count_ff <= '0;
         day_ff          <= ffws_pkg::DAY_BITS'(1);
         served_ff       <= '0;
         chk_vld_ff      <= 1'b0;
         granted_ff      <= 1'b0;
         hit_idx_ff      <= '0;
      end else begin
         if (do_load) begin
            served_ff[entry_count_ff[ffws_pkg::JOB_BITS-1:0]] <= 1'b0;
            entry_count_ff <= entry_count_ff + ffws_pkg::COUNT_BITS'(1);
         end
         chk_vld_ff <= issue && !finish;
         if (accept && (req_data.action == ffws_pkg::ACT_TICK)) begin
            granted_ff <= 1'b0;
            hit_idx_ff <= '0;
         end
         if (finish && match) begin
            served_ff[chk_idx_ff] <= 1'b1;
            served_count_ff       <= served_count_ff + ffws_pkg::COUNT_BITS'(1);
            granted_ff            <= 1'b1;
            hit_idx_ff            <= chk_idx_ff;
         end
         if ((state_ff == ffws_pkg::ST_DONE) && out_ready && (day_ff != DayMax)) begin
            day_ff <= day_ff + ffws_pkg::DAY_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ffws_pkg::ST_IDLE) begin
         scan_idx_ff <= '0;
      end else if (issue) begin
         scan_idx_ff <= scan_idx_ff + ffws_pkg::COUNT_BITS'(1);
      end
      chk_idx_ff <= scan_idx_ff[ffws_pkg::JOB_BITS-1:0];
   end

   assign res_data.day          = day_ff;
   assign res_data.granted      = granted_ff;
   assign res_data.job_index    = hit_idx_ff;
   assign res_data.served_total = served_count_ff;
endmodule
`default_nettype wire

// ===== src/first_fit_window_job_scheduler_top.sv =====
// Top level of the first-fit window job scheduler with its result output register.
//
// A load transfer (action 0) stores one job window and gives no result; loads past 64
// entries are dropped. A tick transfer (action 1) scans the stored windows through one
// compare unit, one entry per cycle from the lowest index, stopping at the first unserved
// job whose window holds the current day. The single memory read port feeds the compare
// unit through its read register; the result then sits in an output register so the next
// transfer can be taken while it waits. The day starts at 1 and saturates at 65535.
`default_nettype none
module first_fit_window_job_scheduler_top (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire ffws_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output ffws_pkg::rsp_type      rsp_data
);
   logic              res_valid;
   ffws_pkg::rsp_type res_data;
   logic              out_ready;
   logic              rsp_valid_ff;
   ffws_pkg::rsp_type rsp_data_ff;

   assign out_ready = !rsp_valid_ff || !rsp_stall;

   ffws_scan_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .res_valid (res_valid),
      .res_data  (res_data),
      .out_ready (out_ready)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && out_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && out_ready) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_grant_zero_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.granted) |-> (rsp_data.job_index == '0))
      else $error("result without a grant carries a nonzero job index");

   a_tick_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && (req_data.action == ffws_pkg::ACT_TICK)) |=> req_stall)
      else $error("input taken again right after a tick transfer");

   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.served_total <= ffws_pkg::COUNT_BITS'(ffws_pkg::MAX_JOBS)))
      else $error("served total exceeds table capacity");

   a_day_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.day != '0))
      else $error("result reports day zero");
endmodule
`default_nettype wire
